### design/egt_pkg.sv
// Shared types, codes and helpers for the epoch grace tracker.
package egt_pkg;

  localparam int WORKERS_DEF = 64;
  localparam int WORKER_W    = 6;
  localparam int ACTION_W    = 3;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_REGISTER   = 3'd0,
    ACT_UNREGISTER = 3'd1,
    ACT_ENTER      = 3'd2,
    ACT_EXIT       = 3'd3,
    ACT_SYNC       = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_NOT_REGISTERED = 2'd1,
    ST_NOT_ACTIVE     = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  function automatic logic [1:0] next_epoch(input logic [1:0] e);
    return (e >= 2'd2) ? 2'd0 : e + 2'd1;
  endfunction

endpackage

### design/egt_ctrl.sv
// Controller state machine: sequences capture and commit of one beat.
module egt_ctrl
  import egt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.commit = stat.out_free;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### design/egt_dp.sv
// Datapath: worker table, epoch, occupancy counters and result register.
module egt_dp
  import egt_pkg::*;
#(
  parameter int WORKERS = WORKERS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int DEPTH = (WORKERS > (1 << WORKER_W)) ? (1 << WORKER_W) : WORKERS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [WORKER_W:0] LIMIT = (WORKER_W + 1)'(DEPTH);

  // entry: {present, active, seen[1:0]}
  logic [3:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid;

  logic [1:0]    global_count;
  logic [CW-1:0] cnt_act;
  logic [CW-1:0] cnt_cur;

  action_t       action_q;
  logic          inr_q;
  logic [AW-1:0] addr_q;
  logic [3:0]    rd_q;
  logic          vld_q;

  logic [ACTION_W-1:0] in_action;
  logic [WORKER_W-1:0] in_worker;
  logic                in_inr;
  logic [AW-1:0]       in_addr;

  assign in_action = s_tdata[ACTION_W-1:0];
  assign in_worker = s_tdata[ACTION_W +: WORKER_W];
  assign in_inr    = {1'b0, in_worker} < LIMIT;
  assign in_addr   = in_inr ? in_worker[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_q <= action_t'(in_action);
      inr_q    <= in_inr;
      addr_q   <= in_addr;
      rd_q     <= mem[in_addr];
      vld_q    <= valid[in_addr];
    end
  end

  logic [3:0] ent;
  logic       p_old, a_old;
  logic [1:0] s_old;
  logic [3:0] ent_new;
  logic       wr_en;
  status_t    status;
  logic       announced;
  logic [1:0] g_next;
  logic       act_old, cur_old, act_new, cur_new;
  logic [CW-1:0] cnt_act_next, cnt_cur_next;

  always_comb begin
    ent       = vld_q ? rd_q : 4'd0;
    p_old     = ent[3];
    a_old     = ent[2];
    s_old     = ent[1:0];
    ent_new   = ent;
    wr_en     = 1'b0;
    status    = ST_OK;
    announced = 1'b0;
    g_next    = global_count;
    unique case (action_q)
      ACT_REGISTER: begin
        if (!inr_q) status = ST_NOT_REGISTERED;
        else begin
          ent_new = 4'b1000;
          wr_en   = 1'b1;
        end
      end
      ACT_UNREGISTER: begin
        if (inr_q && p_old) begin
          ent_new = 4'b0000;
          wr_en   = 1'b1;
        end
      end
      ACT_ENTER: begin
        if (!inr_q || !p_old) status = ST_NOT_REGISTERED;
        else begin
          ent_new = {2'b11, global_count};
          wr_en   = 1'b1;
        end
      end
      ACT_EXIT: begin
        if (!inr_q || !p_old) status = ST_NOT_REGISTERED;
        else if (!a_old) status = ST_NOT_ACTIVE;
        else begin
          ent_new = 4'b1000;
          wr_en   = 1'b1;
        end
      end
      ACT_SYNC: begin
        if (cnt_cur == cnt_act) begin
          g_next    = next_epoch(global_count);
          announced = 1'b1;
        end
      end
      default: ;
    endcase

    act_old = p_old & a_old;
    cur_old = act_old & (s_old == global_count);
    act_new = ent_new[3] & ent_new[2];
    cur_new = act_new & (ent_new[1:0] == global_count);
    if (announced) begin
      cnt_act_next = cnt_act;
      cnt_cur_next = '0;
    end else if (wr_en) begin
      cnt_act_next = cnt_act - CW'(act_old) + CW'(act_new);
      cnt_cur_next = cnt_cur - CW'(cur_old) + CW'(cur_new);
    end else begin
      cnt_act_next = cnt_act;
      cnt_cur_next = cnt_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem[addr_q] <= ent_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      global_count <= 2'd0;
      cnt_act      <= '0;
      cnt_cur      <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cmd.commit) begin
        if (wr_en) valid[addr_q] <= 1'b1;
        global_count <= g_next;
        cnt_act      <= cnt_act_next;
        cnt_cur      <= cnt_cur_next;
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {1'b0, g_next, next_epoch(g_next), announced, status};
    end
  end

  assign stat.out_free = !m_tvalid || m_tready;

endmodule

### design/epoch_grace_tracker.sv
// Top level of the three-epoch grace tracker.
//
//  channel  dir  handshake            tdata
//  s_*      in   s_tvalid/s_tready    [2:0] action, [8:3] worker
//  m_*      out  m_tvalid/m_tready    [1:0] status, [2] announced,
//                                     [4:3] reclaim_epoch, [6:5] staging_epoch
//
// Every beat is captured, reading the worker table entry, and then committed,
// updating it and loading the result register. Sync is settled from two
// occupancy counters, so it costs the same as any other action.
// Reset is synchronous; the table is cleared at once via per-entry valid bits.
// A held result stalls commit; s_tready stays low until the pending beat commits.
module epoch_grace_tracker
  import egt_pkg::*;
#(
  parameter int WORKERS = WORKERS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // action, worker
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // status, announced, reclaim_epoch, staging_epoch
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  egt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  egt_dp #(
    .WORKERS (WORKERS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("beat accepted while previous still in progress");

  a_epoch_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6:5] != 2'd3))
    else $error("staging epoch out of range");

  a_reclaim_follows: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[4:3] == next_epoch(m_tdata[6:5])))
    else $error("reclaim epoch not one past staging epoch");

  a_announce_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2]) |-> (m_tdata[1:0] == ST_OK))
    else $error("announce with error status");

endmodule

### tb/testbench.sv
// Self-checking testbench for the epoch grace tracker stream block.
module testbench;
  import egt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ACTION_W-1:0] ACT_RSVD5 = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_RSVD7 = 3'd7;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_BEATS = 1250;

  typedef struct packed {
    status_t    status;
    logic       announced;
    logic [1:0] reclaim_epoch;
    logic [1:0] staging_epoch;
  } grace_result_t;

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [WORKER_W-1:0] worker;
    bit                  typed;
    grace_result_t       want;
  } script_row_t;

  localparam grace_result_t PREDICTED = '0;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // shared between sender and receiver, written with nonblocking assignments
  logic calm = 1'b0;
  logic want_hold = 1'b0;

  // shadow of the tracker state
  bit [1:0] epoch_now;
  bit       enrolled [WORKERS_DEF];
  bit       busy [WORKERS_DEF];
  bit [1:0] seen_epoch [WORKERS_DEF];

  grace_result_t expected_results [$];
  int mismatch_count = 0;

  epoch_grace_tracker uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit [1:0] advance_epoch(input bit [1:0] e);
    return (e == 2'd2) ? 2'd0 : e + 2'd1;
  endfunction

  // 6-bit worker field with 64 workers: every index is in range
  function automatic grace_result_t grace_step(input logic [ACTION_W-1:0] act,
                                               input logic [WORKER_W-1:0] w);
    grace_result_t res;
    bit caught_up;
    res = '0;
    res.status = ST_OK;
    case (act)
      ACT_REGISTER: begin
        enrolled[w] = 1'b1;
        busy[w] = 1'b0;
        seen_epoch[w] = 2'd0;
      end
      ACT_UNREGISTER: begin
        if (enrolled[w]) begin
          enrolled[w] = 1'b0;
          busy[w] = 1'b0;
          seen_epoch[w] = 2'd0;
        end
      end
      ACT_ENTER: begin
        if (!enrolled[w]) begin
          res.status = ST_NOT_REGISTERED;
        end else begin
          busy[w] = 1'b1;
          seen_epoch[w] = epoch_now;
        end
      end
      ACT_EXIT: begin
        if (!enrolled[w]) begin
          res.status = ST_NOT_REGISTERED;
        end else if (!busy[w]) begin
          res.status = ST_NOT_ACTIVE;
        end else begin
          busy[w] = 1'b0;
          seen_epoch[w] = 2'd0;
        end
      end
      ACT_SYNC: begin
        caught_up = 1'b1;
        foreach (enrolled[i])
          if (enrolled[i] && busy[i] && seen_epoch[i] != epoch_now) caught_up = 1'b0;
        if (caught_up) begin
          epoch_now = advance_epoch(epoch_now);
          res.announced = 1'b1;
        end
      end
      default: ;
    endcase
    res.reclaim_epoch = advance_epoch(epoch_now);
    res.staging_epoch = epoch_now;
    return res;
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatch_count < 50) $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic send_beat(input logic [ACTION_W-1:0] act, input logic [WORKER_W-1:0] w,
                           input bit typed, input grace_result_t want);
    grace_result_t predicted;
    while (!calm && $urandom_range(99) < 36) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_DATA_W - WORKER_W - ACTION_W){1'b0}}, w, act};
    do @(posedge clk); while (!s_tready);
    predicted = grace_step(act, w);
    expected_results.push_back(typed ? want : predicted);
  endtask

  task automatic check_beat(input logic [OUT_DATA_W-1:0] beat);
    grace_result_t want;
    if (expected_results.size() == 0) begin
      flag_mismatch($sformatf("unexpected result beat %h", beat));
    end else begin
      want = expected_results.pop_front();
      if (beat[1:0] !== want.status)
        flag_mismatch($sformatf("status got %0d want %0d", beat[1:0], want.status));
      if (beat[2] !== want.announced)
        flag_mismatch($sformatf("announced got %0d want %0d", beat[2], want.announced));
      if (beat[4:3] !== want.reclaim_epoch)
        flag_mismatch($sformatf("reclaim_epoch got %0d want %0d", beat[4:3],
                                want.reclaim_epoch));
      if (beat[6:5] !== want.staging_epoch)
        flag_mismatch($sformatf("staging_epoch got %0d want %0d", beat[6:5],
                                want.staging_epoch));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_beat(m_tdata);
  end

  // receiver: random back-pressure, one long hold-off on request
  int hold_count = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (want_hold && hold_count < HOLD_CYCLES) begin
      m_tready <= 1'b0;
      hold_count++;
    end else if (calm) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 36);
    end
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    script_row_t script [24];
    logic [ACTION_W-1:0] act;
    logic [WORKER_W-1:0] w;
    logic [WORKER_W-1:0] pool [8];
    int r;

    script = '{
      '{ACT_SYNC,       6'd0,  1'b1, '{ST_OK, 1'b1, 2'd2, 2'd1}},
      '{ACT_ENTER,      6'd63, 1'b1, '{ST_NOT_REGISTERED, 1'b0, 2'd2, 2'd1}},
      '{ACT_EXIT,       6'd0,  1'b1, '{ST_NOT_REGISTERED, 1'b0, 2'd2, 2'd1}},
      '{ACT_UNREGISTER, 6'd5,  1'b1, '{ST_OK, 1'b0, 2'd2, 2'd1}},
      '{ACT_REGISTER,   6'd0,  1'b1, '{ST_OK, 1'b0, 2'd2, 2'd1}},
      '{ACT_REGISTER,   6'd63, 1'b1, '{ST_OK, 1'b0, 2'd2, 2'd1}},
      '{ACT_REGISTER,   6'd0,  1'b1, '{ST_OK, 1'b0, 2'd2, 2'd1}},
      '{ACT_EXIT,       6'd0,  1'b1, '{ST_NOT_ACTIVE, 1'b0, 2'd2, 2'd1}},
      '{ACT_ENTER,      6'd0,  1'b0, PREDICTED},
      '{ACT_ENTER,      6'd63, 1'b0, PREDICTED},
      '{ACT_SYNC,       6'd0,  1'b0, PREDICTED},
      '{ACT_SYNC,       6'd0,  1'b0, PREDICTED},
      '{ACT_EXIT,       6'd0,  1'b0, PREDICTED},
      '{ACT_SYNC,       6'd21, 1'b0, PREDICTED},
      '{ACT_ENTER,      6'd63, 1'b0, PREDICTED},
      '{ACT_SYNC,       6'd42, 1'b0, PREDICTED},
      '{ACT_RSVD5,      6'd42, 1'b0, PREDICTED},
      '{ACT_RSVD6,      6'd21, 1'b0, PREDICTED},
      '{ACT_RSVD7,      6'd63, 1'b0, PREDICTED},
      '{ACT_UNREGISTER, 6'd63, 1'b0, PREDICTED},
      '{ACT_EXIT,       6'd63, 1'b0, PREDICTED},
      '{ACT_SYNC,       6'd63, 1'b0, PREDICTED},
      '{ACT_UNREGISTER, 6'd0,  1'b0, PREDICTED},
      '{ACT_ENTER,      6'd42, 1'b0, PREDICTED}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_beat(script[i].act, script[i].worker, script[i].typed,
                                  script[i].want);

    pool = '{6'd0, 6'd63, 6'd1, 6'd62, 6'd21, 6'd42, 6'd7, 6'd56};
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == 300) want_hold <= 1'b1;
      if (n == 700) calm <= 1'b1;
      if (n == 900) calm <= 1'b0;
      if (n > 0 && n % 200 == 0)
        foreach (pool[k]) pool[k] = WORKER_W'($urandom_range(63));
      r = $urandom_range(99);
      if ($urandom_range(99) < 30) begin
        act = ACTION_W'($urandom_range(7));
        w = WORKER_W'($urandom_range(63));
      end else begin
        w = pool[$urandom_range(7)];
        if (r < 25) act = ACT_SYNC;
        else if (!enrolled[w]) act = ACT_REGISTER;
        else if (!busy[w]) act = (r < 35) ? ACT_UNREGISTER : ACT_ENTER;
        else act = (r < 70) ? ACT_EXIT : ACT_ENTER;
      end
      send_beat(act, w, 1'b0, PREDICTED);
    end
    s_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
